/* rtl/core/slrt_pkg.sv */
// slrt_pkg: shared types and constants of the sparse leftmost-row transpose unit
// holds the size limits, action/array/status/register codes and the sequencer state type
// no dependencies
package slrt_pkg;

    localparam int MaxRows    = 256;
    localparam int MaxCols    = 256;
    localparam int MaxEntries = 4096;

    localparam logic [2:0] ACT_LOAD_PTR   = 3'd0;
    localparam logic [2:0] ACT_LOAD_ROW   = 3'd1;
    localparam logic [2:0] ACT_LOAD_ORDER = 3'd2;
    localparam logic [2:0] ACT_COMPUTE    = 3'd3;
    localparam logic [2:0] ACT_READ       = 3'd4;

    localparam logic [1:0] ARR_INV_ROW  = 2'd0;
    localparam logic [1:0] ARR_RANGES   = 2'd1;
    localparam logic [1:0] ARR_ROW_PTR  = 2'd2;
    localparam logic [1:0] ARR_COLUMNS  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    localparam logic [1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [1:0] REG_NUM_COLS = 2'd1;
    localparam logic [1:0] REG_IDENTITY = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_INIT,
        S_W_COL,
        S_W_ORD,
        S_W_CP0,
        S_W_CP1,
        S_W_ENT,
        S_W_RI,
        S_W_IRO,
        S_W_RC,
        S_W_COLEND,
        S_P_LR,
        S_P_LRW,
        S_P_TAIL0,
        S_P_TAIL1,
        S_E_ROW,
        S_R_PRE,
        S_R_PREW,
        S_DONE
    } state_t;

endpackage

/* rtl/core/slrt_ram.sv */
// slrt_ram: generic single-write, single-read RAM with registered read data
// used for every store of the unit; depends on nothing
module slrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sparse_leftmost_row_transpose_unit.sv */
// sparse_leftmost_row_transpose_unit: top level, item sequencer and stores
// depends on slrt_pkg and slrt_ram
//
// usage:
//   s_* channel takes one item per transfer: load column pointer, load row
//   index, load column order, compute, or read one word of a result array.
//   m_* channel returns exactly one result per item (value plus status).
//   cfg_* channel writes num_rows, num_cols and use_identity_order; write
//   them only while idle; the unit itself does not enforce it.
// timing:
//   load items and rejected reads answer in the cycle after the transfer; a
//   good read goes through the registered RAM read, then the result register.
//   The unit works on one item at a time. A compute item walks the columns,
//   takes prefix sums over the leftmost ranges, numbers the empty rows, takes
//   prefix sums over the row counts, walks the columns again to fill in the
//   result, and finishes; each store takes one read and one write at a time.
// reset:
//   registers go to their reset values and results read as not computed;
//   stores hold nothing until loaded, no clearing pass is needed.
// stall:
//   a result waits in the output register; s_tready stays low until it is
//   taken, so no result is lost.
module sparse_leftmost_row_transpose_unit (
    input  logic        clk,
    input  logic        rst_n,
    // action [2:0], index [15:3], value [28:16], zero fill [31:29]
    input  logic [31:0] s_tdata,
    // which_array [1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // result_value [12:0], zero fill [15:13]
    output logic [15:0] m_tdata,
    // status [1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    import slrt_pkg::*;

    // input fields
    logic [2:0]  in_action;
    logic [12:0] in_index;
    logic [12:0] in_value;
    logic [1:0]  in_which;
    logic        in_xfer;

    assign in_action = s_tdata[2:0];
    assign in_index  = s_tdata[15:3];
    assign in_value  = s_tdata[28:16];
    assign in_which  = s_tuser;

    // registers
    state_t      state_reg, state_next;
    logic [8:0]  num_rows_reg, num_rows_next;
    logic [8:0]  num_cols_reg, num_cols_next;
    logic        ident_reg, ident_next;
    logic        out_valid_reg, out_valid_next;
    logic [12:0] out_value_reg, out_value_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [1:0]  rd_which_reg, rd_which_next;
    logic        computed_reg, computed_next;
    logic [8:0]  snap_m_reg, snap_m_next;
    logic [8:0]  snap_n_reg, snap_n_next;
    logic [12:0] snap_nnz_reg, snap_nnz_next;
    logic [255:0] seen_reg, seen_next;
    logic        pass_reg, pass_next;
    logic [8:0]  col_reg, col_next;
    logic [8:0]  k_reg, k_next;
    logic [8:0]  kstart_reg, kstart_next;
    logic [12:0] used_reg, used_next;
    logic [12:0] p_reg, p_next;
    logic [12:0] pend_reg, pend_next;
    logic [8:0]  j_reg, j_next;
    logic [7:0]  r_reg, r_next;
    logic [8:0]  idx_reg, idx_next;
    logic [12:0] sum_reg, sum_next;
    logic [8:0]  nonempty_reg, nonempty_next;

    // clamped sizes
    logic [8:0] m_eff;
    logic [8:0] n_eff;
    assign m_eff = (num_rows_reg > 9'(MaxRows)) ? 9'(MaxRows) : num_rows_reg;
    assign n_eff = (num_cols_reg > 9'(MaxCols)) ? 9'(MaxCols) : num_cols_reg;

    // store ports
    logic        cp_we;   logic [8:0]  cp_wa;  logic [12:0] cp_wd;
    logic [8:0]  cp_ra;   logic [12:0] cp_rd;
    logic        ri_we;   logic [11:0] ri_wa;  logic [12:0] ri_wd;
    logic [11:0] ri_ra;   logic [12:0] ri_rd;
    logic        co_we;   logic [7:0]  co_wa;  logic [12:0] co_wd;
    logic [7:0]  co_ra;   logic [12:0] co_rd;
    logic        iro_we;  logic [7:0]  iro_wa; logic [8:0]  iro_wd;
    logic [7:0]  iro_ra;  logic [8:0]  iro_rd;
    logic        rc_we;   logic [7:0]  rc_wa;  logic [12:0] rc_wd;
    logic [7:0]  rc_ra;   logic [12:0] rc_rd;
    logic        lr_we;   logic [8:0]  lr_wa;  logic [8:0]  lr_wd;
    logic [8:0]  lr_ra;   logic [8:0]  lr_rd;
    logic        rp_we;   logic [8:0]  rp_wa;  logic [12:0] rp_wd;
    logic [8:0]  rp_ra;   logic [12:0] rp_rd;
    logic        rcol_we; logic [11:0] rcol_wa; logic [7:0] rcol_wd;
    logic [11:0] rcol_ra; logic [7:0]  rcol_rd;

    slrt_ram #(.WIDTH(13), .DEPTH(MaxCols + 1)) u_col_ptr (
        .clk(clk), .we(cp_we), .waddr(cp_wa), .wdata(cp_wd), .raddr(cp_ra), .rdata(cp_rd));
    slrt_ram #(.WIDTH(13), .DEPTH(MaxEntries)) u_row_idx (
        .clk(clk), .we(ri_we), .waddr(ri_wa), .wdata(ri_wd), .raddr(ri_ra), .rdata(ri_rd));
    slrt_ram #(.WIDTH(13), .DEPTH(MaxCols)) u_col_order (
        .clk(clk), .we(co_we), .waddr(co_wa), .wdata(co_wd), .raddr(co_ra), .rdata(co_rd));
    slrt_ram #(.WIDTH(9), .DEPTH(MaxRows)) u_inv_row (
        .clk(clk), .we(iro_we), .waddr(iro_wa), .wdata(iro_wd), .raddr(iro_ra),
        .rdata(iro_rd));
    slrt_ram #(.WIDTH(13), .DEPTH(MaxRows)) u_row_cnt (
        .clk(clk), .we(rc_we), .waddr(rc_wa), .wdata(rc_wd), .raddr(rc_ra), .rdata(rc_rd));
    slrt_ram #(.WIDTH(9), .DEPTH(MaxCols + 2)) u_ranges (
        .clk(clk), .we(lr_we), .waddr(lr_wa), .wdata(lr_wd), .raddr(lr_ra), .rdata(lr_rd));
    slrt_ram #(.WIDTH(13), .DEPTH(MaxRows + 1)) u_row_ptr (
        .clk(clk), .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd));
    slrt_ram #(.WIDTH(8), .DEPTH(MaxEntries)) u_res_col (
        .clk(clk), .we(rcol_we), .waddr(rcol_wa), .wdata(rcol_wd), .raddr(rcol_ra),
        .rdata(rcol_rd));

    // handshakes and outputs
    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_value_reg};
    assign m_tuser   = out_status_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_rows_reg   <= '0;
            num_cols_reg   <= '0;
            ident_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
            computed_reg   <= 1'b0;
            snap_m_reg     <= '0;
            snap_n_reg     <= '0;
            snap_nnz_reg   <= '0;
            seen_reg       <= '0;
            pass_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_rows_reg   <= num_rows_next;
            num_cols_reg   <= num_cols_next;
            ident_reg      <= ident_next;
            out_valid_reg  <= out_valid_next;
            computed_reg   <= computed_next;
            snap_m_reg     <= snap_m_next;
            snap_n_reg     <= snap_n_next;
            snap_nnz_reg   <= snap_nnz_next;
            seen_reg       <= seen_next;
            pass_reg       <= pass_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        rd_which_reg   <= rd_which_next;
        col_reg        <= col_next;
        k_reg          <= k_next;
        kstart_reg     <= kstart_next;
        used_reg       <= used_next;
        p_reg          <= p_next;
        pend_reg       <= pend_next;
        j_reg          <= j_next;
        r_reg          <= r_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        nonempty_reg   <= nonempty_next;
    end

    // sequencer
    always_comb
    begin
        logic [12:0] jw;
        logic [12:0] row_i;

        state_next      = state_reg;
        num_rows_next   = num_rows_reg;
        num_cols_next   = num_cols_reg;
        ident_next      = ident_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        rd_which_next   = rd_which_reg;
        computed_next   = computed_reg;
        snap_m_next     = snap_m_reg;
        snap_n_next     = snap_n_reg;
        snap_nnz_next   = snap_nnz_reg;
        seen_next       = seen_reg;
        pass_next       = pass_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        kstart_next     = kstart_reg;
        used_next       = used_reg;
        p_next          = p_reg;
        pend_next       = pend_reg;
        j_next          = j_reg;
        r_next          = r_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        nonempty_next   = nonempty_reg;
        jw              = '0;
        row_i           = ri_rd;

        cp_we = 1'b0;   cp_wa = in_index[8:0];   cp_wd = in_value;  cp_ra = '0;
        ri_we = 1'b0;   ri_wa = in_index[11:0];  ri_wd = in_value;  ri_ra = '0;
        co_we = 1'b0;   co_wa = in_index[7:0];   co_wd = in_value;  co_ra = '0;
        iro_we = 1'b0;  iro_wa = '0;  iro_wd = '0;  iro_ra = '0;
        rc_we = 1'b0;   rc_wa = '0;   rc_wd = '0;   rc_ra = '0;
        lr_we = 1'b0;   lr_wa = '0;   lr_wd = '0;   lr_ra = '0;
        rp_we = 1'b0;   rp_wa = '0;   rp_wd = '0;   rp_ra = '0;
        rcol_we = 1'b0; rcol_wa = '0; rcol_wd = '0; rcol_ra = '0;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS: num_rows_next = cfg_data;
                REG_NUM_COLS: num_cols_next = cfg_data;
                REG_IDENTITY: ident_next    = cfg_data[0];
                default: ;
            endcase
        end

        // result taken
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    out_value_next  = '0;
                    out_status_next = ST_OK;
                    out_valid_next  = 1'b1;
                    unique case (in_action)
                        ACT_LOAD_PTR:
                        begin
                            if (in_index <= 13'(MaxCols)) cp_we = 1'b1;
                            else out_status_next = ST_RANGE;
                        end
                        ACT_LOAD_ROW:
                        begin
                            if (in_index < 13'(MaxEntries)) ri_we = 1'b1;
                            else out_status_next = ST_RANGE;
                        end
                        ACT_LOAD_ORDER:
                        begin
                            if (in_index < 13'(MaxCols)) co_we = 1'b1;
                            else out_status_next = ST_RANGE;
                        end
                        ACT_COMPUTE:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_INIT;
                        end
                        ACT_READ:
                        begin
                            rd_which_next = in_which;
                            iro_ra  = in_index[7:0];
                            lr_ra   = in_index[8:0];
                            rp_ra   = in_index[8:0];
                            rcol_ra = in_index[11:0];
                            if (!computed_reg)
                            begin
                                out_status_next = ST_NOT_READY;
                            end
                            else
                            begin
                                unique case (in_which)
                                    ARR_INV_ROW:
                                        if (in_index >= {4'b0, snap_m_reg})
                                            out_status_next = ST_RANGE;
                                    ARR_RANGES:
                                        if (in_index >= {4'b0, snap_n_reg} + 13'd2)
                                            out_status_next = ST_RANGE;
                                    ARR_ROW_PTR:
                                        if (in_index > {4'b0, snap_m_reg})
                                            out_status_next = ST_RANGE;
                                    default:
                                        if (in_index >= snap_nnz_reg
                                            || in_index >= 13'(MaxEntries))
                                            out_status_next = ST_RANGE;
                                endcase
                                if (out_status_next == ST_OK)
                                begin
                                    out_valid_next = 1'b0;
                                    state_next     = S_RD_WAIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                out_valid_next = 1'b1;
                unique case (rd_which_reg)
                    ARR_INV_ROW: out_value_next = {4'b0, iro_rd};
                    ARR_RANGES:  out_value_next = {4'b0, lr_rd};
                    ARR_ROW_PTR: out_value_next = rp_rd;
                    default:     out_value_next = {5'b0, rcol_rd};
                endcase
                state_next = S_IDLE;
            end

            S_INIT:
            begin
                seen_next  = '0;
                pass_next  = 1'b0;
                col_next   = '0;
                k_next     = '0;
                used_next  = '0;
                state_next = S_W_COL;
            end

            // next column of the walk
            S_W_COL:
            begin
                if (col_reg == n_eff)
                begin
                    if (!pass_reg)
                    begin
                        nonempty_next = k_reg;
                        idx_next      = '0;
                        sum_next      = '0;
                        state_next    = S_P_LR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    co_ra      = col_reg[7:0];
                    state_next = S_W_ORD;
                end
            end

            S_W_ORD:
            begin
                jw          = ident_reg ? {4'b0, col_reg} : co_rd;
                kstart_next = k_reg;
                j_next      = jw[8:0];
                if (jw < {4'b0, n_eff})
                begin
                    cp_ra      = jw[8:0];
                    state_next = S_W_CP0;
                end
                else
                begin
                    state_next = S_W_COLEND;
                end
            end

            S_W_CP0:
            begin
                p_next     = cp_rd;
                cp_ra      = j_reg + 9'd1;
                state_next = S_W_CP1;
            end

            S_W_CP1:
            begin
                pend_next  = (cp_rd > 13'(MaxEntries)) ? 13'(MaxEntries) : cp_rd;
                state_next = S_W_ENT;
            end

            S_W_ENT:
            begin
                if (p_reg < pend_reg)
                begin
                    ri_ra      = p_reg[11:0];
                    state_next = S_W_RI;
                end
                else
                begin
                    state_next = S_W_COLEND;
                end
            end

            // one entry of the column
            S_W_RI:
            begin
                p_next     = p_reg + 13'd1;
                state_next = S_W_ENT;
                if (row_i < {4'b0, m_eff} && used_reg < 13'(MaxEntries))
                begin
                    used_next = used_reg + 13'd1;
                    iro_ra    = row_i[7:0];
                    if (!pass_reg && !seen_reg[row_i[7:0]])
                    begin
                        seen_next[row_i[7:0]] = 1'b1;
                        iro_we = 1'b1;
                        iro_wa = row_i[7:0];
                        iro_wd = k_reg;
                        rc_we  = 1'b1;
                        rc_wa  = k_reg[7:0];
                        rc_wd  = 13'd1;
                        k_next = k_reg + 9'd1;
                    end
                    else
                    begin
                        state_next = S_W_IRO;
                    end
                end
            end

            S_W_IRO:
            begin
                r_next     = iro_rd[7:0];
                rc_ra      = iro_rd[7:0];
                state_next = S_W_RC;
            end

            S_W_RC:
            begin
                rc_we = 1'b1;
                rc_wa = r_reg;
                rc_wd = rc_rd + 13'd1;
                if (pass_reg && rc_rd < 13'(MaxEntries))
                begin
                    rcol_we = 1'b1;
                    rcol_wa = rc_rd[11:0];
                    rcol_wd = col_reg[7:0];
                end
                state_next = S_W_ENT;
            end

            S_W_COLEND:
            begin
                if (!pass_reg)
                begin
                    lr_we = 1'b1;
                    lr_wa = col_reg;
                    lr_wd = k_reg - kstart_reg;
                end
                col_next   = col_reg + 9'd1;
                state_next = S_W_COL;
            end

            // prefix sum over leftmost ranges
            S_P_LR:
            begin
                if (idx_reg == n_eff)
                begin
                    state_next = S_P_TAIL0;
                end
                else
                begin
                    lr_ra      = idx_reg;
                    state_next = S_P_LRW;
                end
            end

            S_P_LRW:
            begin
                lr_we      = 1'b1;
                lr_wa      = idx_reg;
                lr_wd      = sum_reg[8:0];
                sum_next   = sum_reg + {4'b0, lr_rd};
                idx_next   = idx_reg + 9'd1;
                state_next = S_P_LR;
            end

            S_P_TAIL0:
            begin
                lr_we      = 1'b1;
                lr_wa      = n_eff;
                lr_wd      = nonempty_reg;
                state_next = S_P_TAIL1;
            end

            S_P_TAIL1:
            begin
                lr_we      = 1'b1;
                lr_wa      = n_eff + 9'd1;
                lr_wd      = m_eff;
                idx_next   = '0;
                state_next = S_E_ROW;
            end

            // empty rows numbered last
            S_E_ROW:
            begin
                if (idx_reg == m_eff)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_R_PRE;
                end
                else
                begin
                    if (!seen_reg[idx_reg[7:0]])
                    begin
                        seen_next[idx_reg[7:0]] = 1'b1;
                        iro_we = 1'b1;
                        iro_wa = idx_reg[7:0];
                        iro_wd = k_reg;
                        rc_we  = 1'b1;
                        rc_wa  = k_reg[7:0];
                        rc_wd  = '0;
                        k_next = k_reg + 9'd1;
                    end
                    idx_next = idx_reg + 9'd1;
                end
            end

            // prefix sum over row counts
            S_R_PRE:
            begin
                if (idx_reg == m_eff)
                begin
                    rp_we      = 1'b1;
                    rp_wa      = m_eff;
                    rp_wd      = sum_reg;
                    pass_next  = 1'b1;
                    col_next   = '0;
                    used_next  = '0;
                    state_next = S_W_COL;
                end
                else
                begin
                    rc_ra      = idx_reg[7:0];
                    state_next = S_R_PREW;
                end
            end

            S_R_PREW:
            begin
                rc_we      = 1'b1;
                rc_wa      = idx_reg[7:0];
                rc_wd      = sum_reg;
                rp_we      = 1'b1;
                rp_wa      = idx_reg;
                rp_wd      = sum_reg;
                sum_next   = sum_reg + rc_rd;
                idx_next   = idx_reg + 9'd1;
                state_next = S_R_PRE;
            end

            S_DONE:
            begin
                snap_m_next     = m_eff;
                snap_n_next     = n_eff;
                snap_nnz_next   = sum_reg;
                computed_next   = 1'b1;
                out_valid_next  = 1'b1;
                out_value_next  = {4'b0, nonempty_reg};
                out_status_next = ST_OK;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
